/* sv/disparity_to_depth_converter_core_macros.svh */
// ----------------------------------------------------------------------------
// Disparity to depth converter assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef DISPARITY_TO_DEPTH_CONVERTER_CORE_MACROS_SVH
`define DISPARITY_TO_DEPTH_CONVERTER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define D2D_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define D2D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/d2d_pkg.sv */
// ----------------------------------------------------------------------------
// d2d_pkg
// Types and constants shared by the disparity to depth converter modules.
// ----------------------------------------------------------------------------
package d2d_pkg;

  // Field widths.
  localparam int DISP_W   = 11;
  localparam int DEPTH_W  = 16;
  localparam int N_W      = 32;
  localparam int REF_W    = 16;
  localparam int OFF_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  // Lookup table size; the address wraps modulo this power of two.
  localparam int DISP_ENTRIES = 2048;
  localparam logic [DISP_W-1:0] DISP_MASK = DISP_W'(DISP_ENTRIES - 1);

  // Divider widths: positive denominator below 2^37, numerator below 2^51.
  localparam int DEN_W = 37;
  localparam int NUM_W = 51;
  localparam int REM_W = 54;
  localparam int Q_W   = 17;
  localparam int DIV_STEPS = Q_W;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

  // Register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_N_COEF   = 2'd0,
    REG_REF_DEPTH = 2'd1,
    REG_DISP_OFF = 2'd2
  } reg_idx_t;

  // Current calibration.
  typedef struct packed {
    logic [N_W-1:0]          n_coef;
    logic [REF_W-1:0]        ref_depth;
    logic signed [OFF_W-1:0] disp_off;
  } cfg_t;

  // Word in flight through the divider.
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [DEN_W-1:0]  den;
    logic [Q_W-1:0]    quo;
    logic [DISP_W-1:0] disp;
    logic              bad;
  } div_t;

endpackage

/* sv/d2d_cfg_regs.sv */
// ----------------------------------------------------------------------------
// d2d_cfg_regs
// Calibration registers written through the configuration channel.
// ----------------------------------------------------------------------------
module d2d_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [d2d_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [d2d_pkg::CFG_DAT_W-1:0]  cfg_wdata,
  output d2d_pkg::cfg_t                  cfg_o
);

  d2d_pkg::cfg_t cfg_r;

  // The register file takes a write in every cycle.
  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  // Decode the index; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.n_coef    <= '0;
      cfg_r.ref_depth <= d2d_pkg::REF_W'(1);
      cfg_r.disp_off  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (d2d_pkg::reg_idx_t'(cfg_index))
        d2d_pkg::REG_N_COEF:    cfg_r.n_coef    <= cfg_wdata;
        d2d_pkg::REG_REF_DEPTH: cfg_r.ref_depth <= cfg_wdata[d2d_pkg::REF_W-1:0];
        d2d_pkg::REG_DISP_OFF:  cfg_r.disp_off  <= cfg_wdata[d2d_pkg::OFF_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/d2d_front.sv */
// ----------------------------------------------------------------------------
// d2d_front
// Two stages that form the numerator and the signed denominator.
// ----------------------------------------------------------------------------
module d2d_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        valid_i,
  input  logic [d2d_pkg::DISP_W-1:0]  disp_i,
  input  d2d_pkg::cfg_t               cfg_i,
  output logic                        valid_o,
  output d2d_pkg::div_t               div_o
);

  logic [d2d_pkg::DISP_W-1:0] addr;
  logic signed [12:0]         s_sum;
  logic signed [29:0]         rs_nxt;
  logic [47:0]                nr_nxt;

  logic                       v1_r;
  logic signed [29:0]         rs_r;
  logic [47:0]                nr_r;
  logic [d2d_pkg::N_W-1:0]    n_r;
  logic [d2d_pkg::DISP_W-1:0] disp_r;

  logic signed [39:0]         den_full;
  d2d_pkg::div_t              div_nxt;
  logic                       v2_r;
  d2d_pkg::div_t              div_r;

  // Stage one: shifted disparity and the two products.
  always_comb begin
    addr   = disp_i & d2d_pkg::DISP_MASK;
    s_sum  = $signed({2'b00, addr}) + $signed({cfg_i.disp_off[7], cfg_i.disp_off, 4'b0000});
    rs_nxt = $signed({1'b0, cfg_i.ref_depth}) * s_sum;
    nr_nxt = 48'(cfg_i.n_coef) * 48'(cfg_i.ref_depth);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rs_r   <= rs_nxt;
      nr_r   <= nr_nxt;
      n_r    <= cfg_i.n_coef;
      disp_r <= disp_i;
    end
  end

  // Stage two: denominator 256*R*s + N and numerator 8*N*R.
  always_comb begin
    den_full     = $signed({{2{rs_r[29]}}, rs_r, 8'h00}) + $signed({8'h00, n_r});
    div_nxt.rem  = d2d_pkg::REM_W'({nr_r, 3'b000});
    div_nxt.den  = den_full[d2d_pkg::DEN_W-1:0];
    div_nxt.quo  = '0;
    div_nxt.disp = disp_r;
    div_nxt.bad  = den_full[39] || (den_full == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_r <= div_nxt;
    end
  end

  assign valid_o = v2_r;
  assign div_o   = div_r;

endmodule

/* sv/d2d_div_step.sv */
// ----------------------------------------------------------------------------
// d2d_div_step
// One registered restoring division step for quotient bit SHIFT.
// ----------------------------------------------------------------------------
module d2d_div_step #(
  parameter int SHIFT = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          valid_i,
  input  d2d_pkg::div_t d_i,
  output logic          valid_o,
  output d2d_pkg::div_t d_o
);

  logic [d2d_pkg::REM_W-1:0] den_sh;
  logic                      take;
  d2d_pkg::div_t             d_nxt;
  logic                      valid_r;
  d2d_pkg::div_t             d_r;

  // Trial subtract of the shifted denominator.
  always_comb begin
    den_sh = d2d_pkg::REM_W'(d_i.den) << SHIFT;
    take   = (d_i.rem >= den_sh);
    d_nxt  = d_i;
    d_nxt.quo = {d_i.quo[d2d_pkg::Q_W-2:0], take};
    if (take) begin
      d_nxt.rem = d_i.rem - den_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r <= d_nxt;
    end
  end

  assign valid_o = valid_r;
  assign d_o     = d_r;

endmodule

/* sv/disparity_to_depth_converter_core.sv */
// The pipeline has 20 register stages from the input to out_*.
// Throughput: one word per cycle while no output word is stalled; the 17-step pipelined divider sets the depth.
// The whole pipeline advances together and holds while an output word is stalled.
// Reset (synchronous, rst_n low) clears all valid bits and loads n = 0,
// reference depth = 1 and offset = 0.
// ----------------------------------------------------------------------------
// disparity_to_depth_converter_core
// Converts a disparity code to a saturated depth word, 8*n / (256*(d + 16*off) + n/R).
// ----------------------------------------------------------------------------
`include "disparity_to_depth_converter_core_macros.svh"

module disparity_to_depth_converter_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [d2d_pkg::DISP_W-1:0]     in_disparity,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [d2d_pkg::DISP_W-1:0]     out_disparity_echo,
  output logic [d2d_pkg::DEPTH_W-1:0]    out_depth_value,
  output logic                           out_saturated,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [d2d_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [d2d_pkg::CFG_DAT_W-1:0]  cfg_wdata
);

  d2d_pkg::cfg_t cfg;
  logic          adv;
  logic          step_v [0:d2d_pkg::DIV_STEPS];
  d2d_pkg::div_t step_d [0:d2d_pkg::DIV_STEPS];

  d2d_pkg::div_t last;
  logic          sat_nxt;
  logic          out_valid_r;
  logic [d2d_pkg::DISP_W-1:0]  out_disp_r;
  logic [d2d_pkg::DEPTH_W-1:0] out_depth_r;
  logic          out_sat_r;

  // The pipeline moves unless a finished word is held at the output.
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  d2d_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  d2d_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .valid_i (in_valid),
    .disp_i  (in_disparity),
    .cfg_i   (cfg),
    .valid_o (step_v[0]),
    .div_o   (step_d[0])
  );

  // Divider: one quotient bit per stage, most significant first.
  for (genvar g = 0; g < d2d_pkg::DIV_STEPS; g++) begin : g_div
    d2d_div_step #(
      .SHIFT (d2d_pkg::DIV_STEPS - 1 - g)
    ) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .valid_i (step_v[g]),
      .d_i     (step_d[g]),
      .valid_o (step_v[g+1]),
      .d_o     (step_d[g+1])
    );
  end

  // Saturate on a bad denominator, a quotient of 65536 or more, or a
  // quotient of 65535 with a remainder.
  always_comb begin
    last    = step_d[d2d_pkg::DIV_STEPS];
    sat_nxt = last.bad || last.quo[d2d_pkg::Q_W-1] ||
              ((last.quo[d2d_pkg::DEPTH_W-1:0] == d2d_pkg::DEPTH_MAX) && (last.rem != '0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= step_v[d2d_pkg::DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_disp_r  <= last.disp;
      out_depth_r <= sat_nxt ? d2d_pkg::DEPTH_MAX : last.quo[d2d_pkg::DEPTH_W-1:0];
      out_sat_r   <= sat_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_disparity_echo = out_disp_r;
  assign out_depth_value    = out_depth_r;
  assign out_saturated      = out_sat_r;

  // A flagged word always carries the ceiling value.
  `D2D_ASSERT_SAME(a_sat_depth, out_valid && out_saturated, out_depth_value == d2d_pkg::DEPTH_MAX, "saturated word without full-scale depth")
  // A stalled output word keeps its depth.
  `D2D_ASSERT_NEXT(a_out_hold, out_valid && out_stall, $stable(out_depth_value), "held word changed")
  // A non-positive denominator reaches the output flagged.
  `D2D_ASSERT_NEXT(a_bad_flagged, adv && step_v[d2d_pkg::DIV_STEPS] && last.bad, out_valid && out_saturated, "bad denominator not flagged")
  // A held output word keeps the pipeline frozen.
  `D2D_ASSERT_SAME(a_hold_freeze, out_valid && out_stall, in_stall, "pipeline moved under a stalled output")

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disparity to depth converter testbench
// Sends disparity words under several calibrations and checks each depth word
// against an exact integer prediction, with random gaps on both channels.
// ----------------------------------------------------------------------------
module testbench;

  // Index with no register behind it; a write there must change nothing.
  localparam logic [d2d_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int GAP_MAX        = 18;
  localparam int DRAIN_CYCLES   = 24;
  localparam int WATCHDOG_LIMIT = 1500;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_WORDS    = 115;

  typedef struct packed {
    logic [d2d_pkg::DISP_W-1:0]  echo;
    logic [d2d_pkg::DEPTH_W-1:0] depth;
    logic                        sat;
  } depth_word_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [d2d_pkg::DISP_W-1:0]    in_disparity;
  logic                          out_valid;
  logic                          out_stall;
  logic [d2d_pkg::DISP_W-1:0]    out_disparity_echo;
  logic [d2d_pkg::DEPTH_W-1:0]   out_depth_value;
  logic                          out_saturated;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [d2d_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [d2d_pkg::CFG_DAT_W-1:0] cfg_wdata;

  // Calibration as the block should hold it after each write.
  logic [d2d_pkg::N_W-1:0]          cal_n    = '0;
  logic [d2d_pkg::REF_W-1:0]        cal_refd = d2d_pkg::REF_W'(1);
  logic signed [d2d_pkg::OFF_W-1:0] cal_off  = '0;

  depth_word_t depth_due_q[$];
  int          fail_count   = 0;
  int          words_sent   = 0;
  int          words_seen   = 0;
  int          sat_seen     = 0;
  int          calibrations = 0;
  int          gap_cap      = GAP_MAX;

  disparity_to_depth_converter_core i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_disparity       (in_disparity),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_disparity_echo (out_disparity_echo),
    .out_depth_value    (out_depth_value),
    .out_saturated      (out_saturated),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Exact depth: floor(8*N*R / (256*R*s + N)), saturated, with s = d + 16*offset.
  function automatic depth_word_t calc_depth_word(input logic [d2d_pkg::DISP_W-1:0] disp);
    depth_word_t word;
    longint      span;
    longint      den;
    longint      num;
    span = longint'(disp % d2d_pkg::DISP_ENTRIES) + 16 * longint'(cal_off);
    den  = 256 * longint'(cal_refd) * span + longint'(cal_n);
    num  = 8 * longint'(cal_n) * longint'(cal_refd);
    word.echo = disp;
    if (den <= 0) begin
      word.depth = d2d_pkg::DEPTH_MAX;
      word.sat   = 1'b1;
    end else if (num > longint'(d2d_pkg::DEPTH_MAX) * den) begin
      word.depth = d2d_pkg::DEPTH_MAX;
      word.sat   = 1'b1;
    end else begin
      word.depth = d2d_pkg::DEPTH_W'(num / den);
      word.sat   = 1'b0;
    end
    return word;
  endfunction

  // Send one disparity word after a random gap; valid stays high afterward.
  task automatic push_disparity(input logic [d2d_pkg::DISP_W-1:0] disp);
    int gap;
    gap = (gap_cap == 0) ? 0 : $urandom_range(0, gap_cap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_disparity <= disp;
    do @(posedge clk); while (in_stall !== 1'b0);
    depth_due_q.push_back(calc_depth_word(disp));
    words_sent++;
  endtask

  // Stop sending and wait until the pipeline has emptied.
  task automatic settle_pipeline();
    in_valid <= 1'b0;
    while (depth_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write; cfg_valid is left high for a following write.
  task automatic write_reg(input logic [d2d_pkg::CFG_IDX_W-1:0] idx,
                           input logic [d2d_pkg::CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      d2d_pkg::REG_N_COEF:    cal_n    = data[d2d_pkg::N_W-1:0];
      d2d_pkg::REG_REF_DEPTH: cal_refd = data[d2d_pkg::REF_W-1:0];
      d2d_pkg::REG_DISP_OFF:  cal_off  = data[d2d_pkg::OFF_W-1:0];
      default: ;
    endcase
  endtask

  // Write the full calibration plus a write to the unused index.
  task automatic load_calibration(input logic [31:0] n_word, refd_word, off_word);
    write_reg(d2d_pkg::REG_N_COEF, n_word);
    write_reg(d2d_pkg::REG_REF_DEPTH, refd_word);
    write_reg(d2d_pkg::REG_DISP_OFF, off_word);
    write_reg(REG_SPARE, $urandom);
    cfg_valid <= 1'b0;
    calibrations++;
  endtask

  // Disparities biased toward the point where the denominator crosses zero.
  function automatic logic [d2d_pkg::DISP_W-1:0] pick_disparity();
    longint knee;
    int     pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      return $urandom_range(0, 1) ? '1 : '0;
    end
    if (pick <= 3 && cal_refd != 0) begin
      knee = -(longint'(cal_n) / (256 * longint'(cal_refd))) - 16 * longint'(cal_off)
             + longint'(int'($urandom_range(0, 8)) - 4);
      if (knee >= 0 && knee < d2d_pkg::DISP_ENTRIES) begin
        return d2d_pkg::DISP_W'(knee);
      end
    end
    return d2d_pkg::DISP_W'($urandom_range(0, d2d_pkg::DISP_ENTRIES - 1));
  endfunction

  // Reset calibration: zero coefficient gives zero depth or a zero denominator.
  task automatic test_reset_calibration();
    settle_pipeline();
    push_disparity('0);
    push_disparity(d2d_pkg::DISP_W'(1));
    push_disparity('1);
  endtask

  // A realistic sensor calibration across the whole disparity range.
  task automatic test_typical_range();
    settle_pipeline();
    load_calibration(32'h000B_B880, 32'h0000_0064, 32'h5A5A_5A00);
    push_disparity('0);
    push_disparity(d2d_pkg::DISP_W'(1));
    push_disparity(d2d_pkg::DISP_W'(11'h2AA));
    push_disparity(d2d_pkg::DISP_W'(11'h555));
    push_disparity(d2d_pkg::DISP_W'(1023));
    push_disparity(d2d_pkg::DISP_W'(1024));
    push_disparity(d2d_pkg::DISP_W'(2046));
    push_disparity('1);
  endtask

  // Quotient just above, exactly at, and just below the depth limit.
  task automatic test_exact_limit();
    settle_pipeline();
    load_calibration(32'd16776960, 32'h0000_FFFF, 32'h0000_0000);
    push_disparity(d2d_pkg::DISP_W'(6));
    push_disparity(d2d_pkg::DISP_W'(7));
    push_disparity(d2d_pkg::DISP_W'(8));
  endtask

  // Most negative offset: denominators negative and zero.
  task automatic test_nonpositive_denominator();
    settle_pipeline();
    load_calibration(32'd256, 32'hABCD_0001, 32'hFFFF_FF80);
    push_disparity('0);
    push_disparity(d2d_pkg::DISP_W'(1000));
    push_disparity('1);
  endtask

  // Zero reference depth, with and without a coefficient.
  task automatic test_zero_reference();
    settle_pipeline();
    load_calibration(32'h0001_2345, 32'hFFFF_0000, 32'h0000_0010);
    push_disparity('0);
    push_disparity('1);
    settle_pipeline();
    load_calibration(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    push_disparity('0);
    push_disparity(d2d_pkg::DISP_W'(11'h3C3));
  endtask

  // Largest coefficient, reference depth and offset together.
  task automatic test_coefficient_extremes();
    settle_pipeline();
    load_calibration(32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0000_007F);
    push_disparity('0);
    push_disparity('1);
  endtask

  // Random calibrations, each followed by a burst of disparity words.
  task automatic test_random_phases();
    logic [d2d_pkg::N_W-1:0]   n_val;
    logic [d2d_pkg::REF_W-1:0] refd_val;
    logic [d2d_pkg::OFF_W-1:0] off_val;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 5))
        0:       n_val = '0;
        1:       n_val = '1;
        2:       n_val = $urandom;
        default: n_val = $urandom_range(256 * 500, 256 * 200000);
      endcase
      case ($urandom_range(0, 7))
        0:       refd_val = '0;
        1:       refd_val = d2d_pkg::REF_W'(1);
        2:       refd_val = '1;
        3:       refd_val = d2d_pkg::REF_W'($urandom);
        default: refd_val = d2d_pkg::REF_W'($urandom_range(20, 2000));
      endcase
      case ($urandom_range(0, 5))
        0:       off_val = 8'h80;
        1:       off_val = 8'h7F;
        2:       off_val = '0;
        3:       off_val = d2d_pkg::OFF_W'($urandom);
        default: off_val = d2d_pkg::OFF_W'(-int'($urandom_range(1, 8)));
      endcase
      // Phase zero pins every register at its maximum; phase one loads n = 1, R = 1 and the most negative offset.
      if (phase == 0) begin
        n_val    = '1;
        refd_val = '1;
        off_val  = 8'h7F;
      end else if (phase == 1) begin
        n_val    = d2d_pkg::N_W'(1);
        refd_val = d2d_pkg::REF_W'(1);
        off_val  = 8'h80;
      end
      settle_pipeline();
      load_calibration(n_val, {16'($urandom), refd_val}, {24'($urandom), off_val});
      gap_cap = (phase % 3 == 2) ? 0 : GAP_MAX;
      repeat (PHASE_WORDS) push_disparity(pick_disparity());
    end
  endtask

  // Result side: a random stall before each word, with quiet stretches.
  initial begin
    int hold;
    int calm_left;
    calm_left = 0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (calm_left > 0) begin
        hold = 0;
        calm_left--;
      end else begin
        hold = $urandom_range(0, GAP_MAX);
        if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(20, 80);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid === 1'b1));
    end
  end

  // Compare each accepted depth word with the oldest prediction.
  always @(posedge clk) begin
    depth_word_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (depth_due_q.size() == 0) begin
        $error("depth word with no pending disparity: echo %0d", out_disparity_echo);
        fail_count++;
      end else begin
        want = depth_due_q.pop_front();
        words_seen++;
        if (out_saturated === 1'b1) sat_seen++;
        if (out_disparity_echo !== want.echo) begin
          $error("disparity_echo: expected %0d, got %0d", want.echo, out_disparity_echo);
          fail_count++;
        end
        if (out_depth_value !== want.depth) begin
          $error("depth_value: expected %0d, got %0d", want.depth, out_depth_value);
          fail_count++;
        end
        if (out_saturated !== want.sat) begin
          $error("saturated: expected %0d, got %0d", want.sat, out_saturated);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too long without any word moving on any channel.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  // Test sequence.
  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_disparity <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_wdata    <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_calibration();
    test_typical_range();
    test_exact_limit();
    test_nonpositive_denominator();
    test_zero_reference();
    test_coefficient_extremes();
    test_random_phases();
    settle_pipeline();

    if (depth_due_q.size() != 0) begin
      $error("%0d depth words never arrived", depth_due_q.size());
      fail_count += depth_due_q.size();
    end
    $display("Sent %0d disparity words under %0d calibrations.", words_sent, calibrations);
    $display("Checked %0d depth words, %0d of them clipped; %0d mismatches.",
             words_seen, sat_seen, fail_count);
    if (fail_count == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
